### sv/drti_pkg.sv
// drti_pkg: shared constants, codes and control structs for the record table insert block
// used by drti_ctrl, drti_dp and dedup_record_table_insert; no dependencies
package drti_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = ADDR_W + 1;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned REC_W    = 3 * WORD_W;

  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned FILL_W   = 9;
  localparam int unsigned RES_W    = STATUS_W + SLOT_W + COUNT_W + FILL_W;
  localparam int unsigned RES_BYTES_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED   = 2'd0,
    STS_PRESENT = 2'd1,
    STS_FULL    = 2'd2
  } result_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic search;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic issue_ok;
    logic cmp_vld;
    logic match;
  } sts_t;

endpackage

### sv/drti_ctrl.sv
// drti_ctrl: controller state machine for the record table insert block
// sequences accept, linear search and commit; depends on drti_pkg
module drti_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output drti_pkg::cmd_t   cmd_o,
  input  drti_pkg::sts_t   sts_i
);

  drti_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drti_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = drti_pkg::ST_SEARCH;
      end
      drti_pkg::ST_SEARCH: begin
        // first hit wins; a miss is known once the read pipe has drained
        if (sts_i.match || (!sts_i.issue_ok && !sts_i.cmp_vld)) begin
          state_d = drti_pkg::ST_FINISH;
        end
      end
      drti_pkg::ST_FINISH: begin
        if (slot_free) state_d = drti_pkg::ST_IDLE;
      end
      default: state_d = drti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      drti_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.start   = s_axis_tvalid;
      end
      drti_pkg::ST_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      drti_pkg::ST_FINISH: begin
        cmd_o.commit = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drti_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || m_axis_tready))
    else $error("commit overwrote a pending result");

  // the search only ends in the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == drti_pkg::ST_SEARCH) |=>
      (state_q == drti_pkg::ST_SEARCH || state_q == drti_pkg::ST_FINISH))
    else $error("search left without finishing");

  // a waiting result stays valid until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");

endmodule

### sv/drti_dp.sv
// drti_dp: datapath of the record table insert block
// record store, search pipeline, fill counters and result register; depends on drti_pkg
module drti_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [drti_pkg::REC_W-1:0]          rec_i,
  input  drti_pkg::cmd_t                      cmd_i,
  output drti_pkg::sts_t                      sts_o,
  output logic [drti_pkg::RES_BYTES_W-1:0]    res_o
);

  logic [drti_pkg::REC_W-1:0]  mem [drti_pkg::CAPACITY];

  logic [drti_pkg::REC_W-1:0]  rec_q;
  logic [drti_pkg::REC_W-1:0]  rd_q;
  logic [drti_pkg::CNT_W-1:0]  k_q;
  logic [drti_pkg::ADDR_W-1:0] cmp_idx_q;
  logic                        cmp_vld_q;
  logic                        hit_q;
  logic [drti_pkg::ADDR_W-1:0] hit_idx_q;
  logic [drti_pkg::CNT_W-1:0]  next_free_q, next_free_d;
  logic [drti_pkg::CNT_W-1:0]  count_q, count_d;
  logic [drti_pkg::RES_BYTES_W-1:0] res_q;

  logic                        issue_ok;
  logic                        match;
  logic                        full;
  logic                        do_write;
  drti_pkg::result_e           res_code;
  logic [drti_pkg::ADDR_W-1:0] res_slot;

  assign issue_ok = k_q < next_free_q;
  assign match    = cmp_vld_q && (rd_q == rec_q);
  assign full     = next_free_q == drti_pkg::CNT_W'(drti_pkg::CAPACITY);

  assign sts_o.issue_ok = issue_ok;
  assign sts_o.cmp_vld  = cmp_vld_q;
  assign sts_o.match    = match;

  always_comb begin
    next_free_d = next_free_q;
    count_d     = count_q;
    do_write    = 1'b0;
    priority if (hit_q) begin
      res_code = drti_pkg::STS_PRESENT;
      res_slot = hit_idx_q;
    end else if (full) begin
      res_code = drti_pkg::STS_FULL;
      res_slot = '0;
    end else begin
      res_code    = drti_pkg::STS_ADDED;
      res_slot    = next_free_q[drti_pkg::ADDR_W-1:0];
      do_write    = cmd_i.commit;
      next_free_d = next_free_q + 1'b1;
      count_d     = count_q + 1'b1;
    end
  end

  // record store: one read port for the search, one write port for the append
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_write) begin
      mem[next_free_q[drti_pkg::ADDR_W-1:0]] <= rec_q;
    end
    if (cmd_i.search && issue_ok) begin
      rd_q <= mem[k_q[drti_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) rec_q <= rec_i;
    if (cmd_i.search && issue_ok) cmp_idx_q <= k_q[drti_pkg::ADDR_W-1:0];
    if (cmd_i.search && match) hit_idx_q <= cmp_idx_q;
    if (cmd_i.commit) begin
      res_q <= drti_pkg::RES_BYTES_W'({
        drti_pkg::FILL_W'(cmd_i.commit && do_write ? next_free_d : next_free_q),
        drti_pkg::COUNT_W'(cmd_i.commit && do_write ? count_d : count_q),
        drti_pkg::SLOT_W'(res_slot),
        res_code
      });
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      next_free_q <= drti_pkg::CNT_W'(1);
      count_q     <= '0;
    end else begin
      if (cmd_i.start) begin
        k_q       <= drti_pkg::CNT_W'(1);
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.search) begin
        cmp_vld_q <= issue_ok;
        if (issue_ok) k_q <= k_q + 1'b1;
        if (match) hit_q <= 1'b1;
      end
      if (cmd_i.commit && do_write) begin
        next_free_q <= next_free_d;
        count_q     <= count_d;
      end
    end
  end

  assign res_o = res_q;

  // reserved slot keeps fill level one ahead of the entry count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q == count_q + drti_pkg::CNT_W'(1))
    else $error("fill level and entry count out of step");

  // a hit points at a stored slot, never the reserved one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (hit_idx_q != '0 &&
               drti_pkg::CNT_W'(hit_idx_q) < next_free_q))
    else $error("hit index outside stored range");

  // nothing is appended once the table is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !do_write)
    else $error("append into a full table");

endmodule

### sv/dedup_record_table_insert.sv
// search: each accepted record is compared against the stored entries in order, ending early
// on the first hit and otherwise once the last stored entry has been compared
// throughput: one record at a time, the next accepted only once the last has been committed
// to the result register; one stored slot read per cycle during the search
// reset: fill level returns to one and entry count to zero; store contents are not cleared
module dedup_record_table_insert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // service_word [31:0], canon_word [63:32], name_word [95:64]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [1:0], slot_index [9:2], entry_count [17:10], fill_level [26:18], zeros above
  output logic [31:0] m_axis_tdata
);

  drti_pkg::cmd_t cmd;
  drti_pkg::sts_t sts;

  drti_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  drti_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (s_axis_tdata),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (m_axis_tdata)
  );

endmodule
